// File: src/scp_pkg.sv
// Package for the sorted color palette table.
// Request codes, status codes, default depth and the controller/datapath command and status structs.
package scp_pkg;

   localparam int PALETTE_DEPTH_DEF = 256;

   localparam logic [1:0] REQ_ADD    = 2'd0;
   localparam logic [1:0] REQ_MAP    = 2'd1;
   localparam logic [1:0] REQ_LOOKUP = 2'd2;
   localparam logic [1:0] REQ_CLEAR  = 2'd3;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_FULL    = 2'd1;
   localparam logic [1:0] ST_MISS    = 2'd2;

   // commands from controller to datapath
   typedef struct packed {
      logic load;        // capture request
      logic srch_init;   // reset binary search bounds
      logic srch_step;   // one search step (alternately issues a read or uses its data)
      logic shift_init;  // start shifting at top
      logic shift_step;  // one move step
      logic put;         // write the new color at pos
      logic clear;       // empty palette
      logic rd_lookup;   // issue lookup read
      logic respond;     // drive response strobe
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic srch_done;
      logic hit;
      logic full;
      logic shift_done;
      logic is_add;
      logic is_lookup;
      logic is_clear;
   } stat_type;

endpackage

// File: src/scp_ram.sv
// Generic simple dual-port RAM (one write port, one read port) with registered read.
// No dependencies.
module scp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data <= mem_ff[rd_addr];
   end
endmodule

// File: src/scp_ctrl.sv
// Controller state machine for the sorted color palette table.
// Depends on scp_pkg.
module scp_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  scp_pkg::stat_type stat,
   output scp_pkg::cmd_type  cmd
);
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_DEC   = 3'd1;
   localparam logic [2:0] S_SRCH  = 3'd2;
   localparam logic [2:0] S_SHIFT = 3'd3;
   localparam logic [2:0] S_PUT   = 3'd4;
   localparam logic [2:0] S_LKUP  = 3'd5;
   localparam logic [2:0] S_RESP  = 3'd6;

   logic [2:0] state_ff, state_in;

   assign busy = (state_ff != S_IDLE);

   // next state and commands
   always_comb begin
      cmd = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (start) begin
            cmd.load = 1'b1;
            state_in = S_DEC;
         end
         S_DEC: begin
            if (stat.is_clear) begin
               cmd.clear = 1'b1;
               state_in = S_RESP;
            end else if (stat.is_lookup) begin
               cmd.rd_lookup = 1'b1;
               state_in = S_LKUP;
            end else begin
               cmd.srch_init = 1'b1;
               state_in = S_SRCH;
            end
         end
         S_SRCH: begin
            if (stat.srch_done) begin
               if (stat.is_add && !stat.hit && !stat.full) begin
                  cmd.shift_init = 1'b1;
                  state_in = S_SHIFT;
               end else state_in = S_RESP;
            end else cmd.srch_step = 1'b1;
         end
         S_SHIFT: begin
            if (stat.shift_done) state_in = S_PUT;
            else cmd.shift_step = 1'b1;
         end
         S_PUT: begin
            cmd.put = 1'b1;
            state_in = S_RESP;
         end
         // keep the lookup address so the entry is still on rd_data in S_RESP
         S_LKUP: begin
            cmd.rd_lookup = 1'b1;
            state_in = S_RESP;
         end
         S_RESP: begin
            cmd.respond = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   // a response only ever follows real work
   assert property (@(posedge clock) disable iff (reset)
      cmd.respond |-> $past(busy))
      else $error("respond while idle");
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not start work");
   assert property (@(posedge clock) disable iff (reset)
      cmd.put |=> cmd.respond)
      else $error("insert not followed by response");
endmodule

// File: src/scp_dp.sv
// Datapath: palette RAM, binary search, insert shift and result registers.
// Depends on scp_pkg and scp_ram.
module scp_dp #(
   parameter int PALETTE_DEPTH = scp_pkg::PALETTE_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  scp_pkg::cmd_type  cmd,
   output scp_pkg::stat_type stat,
   input  logic [1:0]        req_type,
   input  logic [31:0]       req_pixel_color,
   input  logic [7:0]        req_palette_index,
   output logic              rsp_valid,
   output logic [31:0]       rsp_color_result,
   output logic [7:0]       rsp_index_result,
   output logic              rsp_match_found,
   output logic [8:0]        rsp_entry_count,
   output logic [1:0]        rsp_status_code
);
   localparam int AW = $clog2(PALETTE_DEPTH);
   localparam int CW = $clog2(PALETTE_DEPTH + 1);

   logic [1:0]  type_ff;
   logic [31:0] color_ff;
   logic [7:0]  pidx_ff;
   logic [CW-1:0] used_ff;
   logic [CW-1:0] lo_ff, hi_ff;   // search bounds
   logic          rd_pend_ff;     // search read in flight
   logic [CW-1:0] mv_ff;          // shift position (dest)
   logic          mv_ph_ff;       // 0 read phase, 1 write phase
   logic [31:0]   res_c_ff;
   logic          res_m_ff;
   logic [1:0]    res_s_ff;
   logic          valid_ff;
   logic          rsp_put_ff;
   logic [7:0]    idx_ff;

   logic [AW-1:0] rd_addr, wr_addr;
   logic [31:0]   rd_data, wr_data;
   logic          wr_en;
   logic [CW-1:0] mid;
   logic          lk_m;
   logic [8:0]    used_sat;

   assign mid = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign lk_m = (32'(pidx_ff) < 32'(used_ff));

   scp_ram #(.WIDTH(32), .DEPTH(PALETTE_DEPTH)) u_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data));

   // RAM port muxing
   always_comb begin
      rd_addr = mid[AW-1:0];
      wr_en   = 1'b0;
      wr_addr = mv_ff[AW-1:0];
      wr_data = rd_data;
      if (cmd.rd_lookup) rd_addr = AW'(pidx_ff);
      else if (cmd.shift_step) begin
         rd_addr = AW'(mv_ff - CW'(1));
         wr_en   = mv_ph_ff;
      end
      if (cmd.put) begin
         wr_en   = 1'b1;
         wr_addr = lo_ff[AW-1:0];
         wr_data = color_ff;
      end
   end

   assign stat.srch_done  = (lo_ff >= hi_ff) && !rd_pend_ff;
   assign stat.hit        = res_m_ff;
   assign stat.full       = (used_ff >= CW'(PALETTE_DEPTH));
   assign stat.shift_done = (mv_ff <= lo_ff) && !mv_ph_ff;
   assign stat.is_add     = (type_ff == scp_pkg::REQ_ADD);
   assign stat.is_lookup  = (type_ff == scp_pkg::REQ_LOOKUP);
   assign stat.is_clear   = (type_ff == scp_pkg::REQ_CLEAR);

   // request capture, search, shift
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         type_ff  <= req_type;
         color_ff <= req_pixel_color;
         pidx_ff  <= req_palette_index;
      end
      if (cmd.srch_init) begin
         lo_ff      <= '0;
         hi_ff      <= used_ff;
         rd_pend_ff <= 1'b0;
         res_m_ff   <= 1'b0;
      end
      if (cmd.srch_step) begin
         if (!rd_pend_ff) rd_pend_ff <= 1'b1;
         else begin
            rd_pend_ff <= 1'b0;
            if (rd_data < color_ff) lo_ff <= mid + CW'(1);
            else begin
               hi_ff <= mid;
               if (rd_data == color_ff) res_m_ff <= 1'b1;
            end
         end
      end
      // lookup and clear set the match flag in the response cycle
      if (cmd.respond) begin
         if (type_ff == scp_pkg::REQ_LOOKUP) res_m_ff <= lk_m;
         else if (type_ff == scp_pkg::REQ_CLEAR) res_m_ff <= 1'b0;
      end
      if (cmd.shift_init) begin
         mv_ff    <= used_ff;
         mv_ph_ff <= 1'b0;
      end
      if (cmd.shift_step) begin
         mv_ph_ff <= !mv_ph_ff;
         if (mv_ph_ff) mv_ff <= mv_ff - CW'(1);
      end
   end

   // palette size
   always_ff @(posedge clock) begin
      if (reset) used_ff <= '0;
      else if (cmd.clear) used_ff <= '0;
      else if (cmd.put) used_ff <= used_ff + CW'(1);
   end

   // response
   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= cmd.respond;
      if (cmd.respond) begin
         res_c_ff <= '0;
         res_s_ff <= scp_pkg::ST_OK;
         unique case (type_ff)
            scp_pkg::REQ_LOOKUP: begin
               if (lk_m) res_c_ff <= rd_data;
               else res_s_ff <= scp_pkg::ST_MISS;
            end
            scp_pkg::REQ_CLEAR: ;
            scp_pkg::REQ_MAP: begin
               if (res_m_ff) res_c_ff <= color_ff;
               else res_s_ff <= scp_pkg::ST_MISS;
            end
            default: begin
               // add: stored or already there unless dropped
               if (res_m_ff || rsp_put_ff) res_c_ff <= color_ff;
               else res_s_ff <= scp_pkg::ST_FULL;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) rsp_put_ff <= 1'b0;
      else if (cmd.put) rsp_put_ff <= 1'b1;
   end

   // index is set in the response cycle too
   always_ff @(posedge clock) begin
      if (cmd.respond) begin
         unique case (type_ff)
            scp_pkg::REQ_LOOKUP: idx_ff <= pidx_ff;
            scp_pkg::REQ_CLEAR:  idx_ff <= '0;
            default: idx_ff <= (32'(lo_ff) > 32'd255) ? 8'd255 : 8'(lo_ff);
         endcase
      end
   end

   assign used_sat        = (32'(used_ff) > 32'd511) ? 9'd511 : 9'(used_ff);
   assign rsp_valid       = valid_ff;
   assign rsp_color_result = res_c_ff;
   assign rsp_index_result = idx_ff;
   assign rsp_match_found = res_m_ff;
   assign rsp_entry_count = used_sat;
   assign rsp_status_code = res_s_ff;

   assert property (@(posedge clock) disable iff (reset)
      used_ff <= CW'(PALETTE_DEPTH))
      else $error("palette overflow");
   assert property (@(posedge clock) disable iff (reset)
      cmd.put |-> !stat.full)
      else $error("insert into full palette");
   assert property (@(posedge clock) disable iff (reset)
      cmd.srch_step |-> (hi_ff <= used_ff))
      else $error("search bound beyond size");
endmodule

// File: src/sorted_color_palette_table_unit.sv
// Sorted color palette table: top level joining controller and datapath.
// Depends on scp_pkg, scp_ctrl, scp_dp (and scp_ram through it).
//
// One request is taken when start is high and busy low; its single result
// appears on the rsp_ ports for one cycle with rsp_valid and cannot be held
// off. Clear and lookup do no search. Map and add run a binary search over
// the palette RAM (one read per step), and an add that inserts then moves
// the larger entries up one place each, reading and then writing each one
// through the RAM's separate read and write ports.
module sorted_color_palette_table_unit #(
   parameter int PALETTE_DEPTH = scp_pkg::PALETTE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_type,
   input  logic [31:0] req_pixel_color,
   input  logic [7:0]  req_palette_index,
   output logic        rsp_valid,
   output logic [31:0] rsp_color_result,
   output logic [7:0]  rsp_index_result,
   output logic        rsp_match_found,
   output logic [8:0]  rsp_entry_count,
   output logic [1:0]  rsp_status_code
);
   scp_pkg::cmd_type  cmd;
   scp_pkg::stat_type stat;

   scp_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .stat(stat), .cmd(cmd));

   scp_dp #(.PALETTE_DEPTH(PALETTE_DEPTH)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat),
      .req_type(req_type), .req_pixel_color(req_pixel_color),
      .req_palette_index(req_palette_index),
      .rsp_valid(rsp_valid), .rsp_color_result(rsp_color_result),
      .rsp_index_result(rsp_index_result), .rsp_match_found(rsp_match_found),
      .rsp_entry_count(rsp_entry_count), .rsp_status_code(rsp_status_code));
endmodule

// File: tb/sv/testbench.sv
// Tests sorted_color_palette_table_unit: directed table, fill to full, random requests.
// Depends on scp_pkg and the RTL; checks each response beat against a palette predictor.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH = scp_pkg::PALETTE_DEPTH_DEF;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_type = scp_pkg::REQ_CLEAR;
   logic [31:0] req_pixel_color = '0;
   logic [7:0]  req_palette_index = '0;
   logic        rsp_valid;
   logic [31:0] rsp_color_result;
   logic [7:0]  rsp_index_result;
   logic        rsp_match_found;
   logic [8:0]  rsp_entry_count;
   logic [1:0]  rsp_status_code;

   typedef struct packed {
      logic [31:0] color;
      logic [7:0]  index;
      logic        match;
      logic [8:0]  count;
      logic [1:0]  status;
   } palette_rsp_type;

   typedef struct {
      logic [1:0]      op;
      logic [31:0]     color;
      logic [7:0]      index;
      bit              typed;
      palette_rsp_type want;
   } table_row_type;

   // predictor state
   logic [31:0]     pal_colors [DEPTH];
   int unsigned     pal_used;
   palette_rsp_type rsp_expected [$];
   int              errors = 0;
   table_row_type   rows [$];

   sorted_color_palette_table_unit #(.PALETTE_DEPTH(DEPTH)) DUT (
      .clock, .reset, .start, .busy, .req_type, .req_pixel_color, .req_palette_index,
      .rsp_valid, .rsp_color_result, .rsp_index_result, .rsp_match_found,
      .rsp_entry_count, .rsp_status_code
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $realtime);
      errors++;
   endtask

   // work out the response and update the palette copy
   function automatic palette_rsp_type palette_apply(logic [1:0] op, logic [31:0] color,
                                                     logic [7:0] index);
      palette_rsp_type r;
      int unsigned lo, hi, mid;
      bit hit;
      r = '0;
      if (op == scp_pkg::REQ_ADD || op == scp_pkg::REQ_MAP) begin
         lo = 0;
         hi = pal_used;
         while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (pal_colors[mid] < color) lo = mid + 1;
            else hi = mid;
         end
         hit = lo < pal_used && pal_colors[lo] == color;
         r.index = lo > 255 ? 8'd255 : lo[7:0];
         if (hit) begin
            r.color = color;
            r.match = 1'b1;
         end else if (op == scp_pkg::REQ_MAP) begin
            r.status = scp_pkg::ST_MISS;
         end else if (pal_used >= DEPTH) begin
            r.status = scp_pkg::ST_FULL;
         end else begin
            for (int i = pal_used; i > lo; i--) pal_colors[i] = pal_colors[i-1];
            pal_colors[lo] = color;
            pal_used++;
            r.color = color;
         end
      end else if (op == scp_pkg::REQ_LOOKUP) begin
         r.index = index;
         if (index < pal_used) begin
            r.color = pal_colors[index];
            r.match = 1'b1;
         end else begin
            r.status = scp_pkg::ST_MISS;
         end
      end else begin
         pal_used = 0;
      end
      r.count = pal_used > 511 ? 9'd511 : pal_used[8:0];
      return r;
   endfunction

   // drive one request beat; waits until accepted, leaves start high
   task automatic send_request(input logic [1:0] op, input logic [31:0] color,
                               input logic [7:0] index, input bit idle_ok,
                               input bit typed, input palette_rsp_type want);
      palette_rsp_type p;
      if (idle_ok) begin
         while ($urandom_range(99) < 30) begin
            start <= 1'b0;
            @(negedge clock);
         end
      end
      start <= 1'b1;
      req_type <= op;
      req_pixel_color <= color;
      req_palette_index <= index;
      do @(posedge clock); while (busy);
      p = palette_apply(op, color, index);
      if (typed && p != want) begin
         report_mismatch("directed table", p[31:0], want[31:0]);
      end
      rsp_expected.push_back(p);
      @(negedge clock);
   endtask

   // response checker
   always @(posedge clock) begin
      palette_rsp_type w;
      if (!reset && rsp_valid) begin
         if (rsp_expected.size() == 0) begin
            report_mismatch("unexpected response", rsp_color_result, 32'h0);
         end else begin
            w = rsp_expected.pop_front();
            if (rsp_color_result !== w.color)
               report_mismatch("color_result", rsp_color_result, w.color);
            if (rsp_index_result !== w.index)
               report_mismatch("index_result", rsp_index_result, w.index);
            if (rsp_match_found !== w.match)
               report_mismatch("match_found", rsp_match_found, w.match);
            if (rsp_entry_count !== w.count)
               report_mismatch("entry_count", rsp_entry_count, w.count);
            if (rsp_status_code !== w.status)
               report_mismatch("status_code", rsp_status_code, w.status);
         end
      end
   end

   function automatic table_row_type mk(logic [1:0] op, logic [31:0] c, logic [7:0] i,
                                        bit typed, logic [31:0] wc, logic [7:0] wi,
                                        logic wm, logic [8:0] wn, logic [1:0] ws);
      table_row_type t;
      t.op = op; t.color = c; t.index = i; t.typed = typed;
      t.want = '{color: wc, index: wi, match: wm, count: wn, status: ws};
      return t;
   endfunction

   // random color biased toward a small pool so hits and duplicates occur
   function automatic logic [31:0] pick_color();
      case ($urandom_range(3))
         0: return $urandom();
         1: return {$urandom_range(1) ? 32'hFFFF_FF00 : 32'h0} | $urandom_range(255);
         default: return pal_used > 0 ? pal_colors[$urandom_range(pal_used - 1)]
                                      : $urandom();
      endcase
   endfunction

   initial begin
      logic [1:0] op;
      int k;
      // directed rows: empty palette, extremes, hits, misses, clear
      rows.push_back(mk(scp_pkg::REQ_LOOKUP, 0, 8'd0, 1, 0, 8'd0, 0, 0, scp_pkg::ST_MISS));
      rows.push_back(mk(scp_pkg::REQ_MAP, 32'hFFFF_FFFF, 0, 1, 0, 8'd0, 0, 0,
                        scp_pkg::ST_MISS));
      rows.push_back(mk(scp_pkg::REQ_ADD, 32'hFFFF_FFFF, 0, 1, 32'hFFFF_FFFF, 8'd0, 0, 1,
                        scp_pkg::ST_OK));
      rows.push_back(mk(scp_pkg::REQ_ADD, 32'h0, 0, 1, 32'h0, 8'd0, 0, 2, scp_pkg::ST_OK));
      rows.push_back(mk(scp_pkg::REQ_ADD, 32'h8000_0000, 0, 1, 32'h8000_0000, 8'd1, 0, 3,
                        scp_pkg::ST_OK));
      rows.push_back(mk(scp_pkg::REQ_ADD, 32'h0, 0, 1, 32'h0, 8'd0, 1, 3, scp_pkg::ST_OK));
      rows.push_back(mk(scp_pkg::REQ_MAP, 32'hFFFF_FFFF, 0, 1, 32'hFFFF_FFFF, 8'd2, 1, 3,
                        scp_pkg::ST_OK));
      rows.push_back(mk(scp_pkg::REQ_MAP, 32'h7FFF_FFFF, 0, 1, 0, 8'd1, 0, 3,
                        scp_pkg::ST_MISS));
      rows.push_back(mk(scp_pkg::REQ_LOOKUP, 0, 8'd2, 1, 32'hFFFF_FFFF, 8'd2, 1, 3,
                        scp_pkg::ST_OK));
      rows.push_back(mk(scp_pkg::REQ_LOOKUP, 0, 8'd3, 1, 0, 8'd3, 0, 3, scp_pkg::ST_MISS));
      rows.push_back(mk(scp_pkg::REQ_LOOKUP, 0, 8'd255, 1, 0, 8'd255, 0, 3,
                        scp_pkg::ST_MISS));
      rows.push_back(mk(scp_pkg::REQ_ADD, 32'h5555_AAAA, 8'hFF, 0, 0, 0, 0, 0, 0));
      rows.push_back(mk(scp_pkg::REQ_ADD, 32'hAAAA_5555, 8'h00, 0, 0, 0, 0, 0, 0));
      rows.push_back(mk(scp_pkg::REQ_LOOKUP, 32'hFFFF_FFFF, 8'd1, 0, 0, 0, 0, 0, 0));
      rows.push_back(mk(scp_pkg::REQ_CLEAR, 32'h1234_5678, 8'd7, 1, 0, 8'd0, 0, 0,
                        scp_pkg::ST_OK));
      rows.push_back(mk(scp_pkg::REQ_LOOKUP, 0, 8'd0, 1, 0, 8'd0, 0, 0, scp_pkg::ST_MISS));
      rows.push_back(mk(scp_pkg::REQ_CLEAR, 0, 0, 1, 0, 8'd0, 0, 0, scp_pkg::ST_OK));

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (rows[i])
         send_request(rows[i].op, rows[i].color, rows[i].index, 1,
                      rows[i].typed, rows[i].want);

      // fill to full, then hit the full-palette drop case
      for (k = 0; k < DEPTH; k++)
         send_request(scp_pkg::REQ_ADD, k * 32'h0101_0101 + 32'h10, 8'(k), k > 200, 0, '0);
      send_request(scp_pkg::REQ_ADD, 32'h0000_0001, 0, 0, 0, '0);
      send_request(scp_pkg::REQ_ADD, 32'hFFFF_FFFF, 0, 0, 0, '0);
      send_request(scp_pkg::REQ_MAP, 32'h10, 0, 0, 0, '0);
      send_request(scp_pkg::REQ_LOOKUP, 0, 8'd255, 0, 0, '0);
      send_request(scp_pkg::REQ_LOOKUP, 0, 8'd0, 0, 0, '0);

      // hold off until the table has drained
      start <= 1'b0;
      wait (rsp_expected.size() == 0);
      @(negedge clock);

      // random traffic; middle stretch has no idling
      for (k = 0; k < 1150; k++) begin
         case ($urandom_range(99)) inside
            [0:44]:  op = scp_pkg::REQ_ADD;
            [45:69]: op = scp_pkg::REQ_MAP;
            [70:97]: op = scp_pkg::REQ_LOOKUP;
            default: op = scp_pkg::REQ_CLEAR;
         endcase
         send_request(op, pick_color(), 8'($urandom_range(255)),
                      !(k >= 400 && k < 600), 0, '0);
      end

      start <= 1'b0;
      wait (rsp_expected.size() == 0);
      repeat (20) @(posedge clock);
      if (errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // watchdog
   initial begin
      #20ms;
      $display("Test completed with failures");
      $finish;
   end

endmodule
